@@ hw/rtl/nfc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared types, sizes and command codes for the NOR flash command model.
// ----------------------------------------------------------------------------
package nfc_pkg;

    // Array geometry; all three are powers of two
    localparam int FLASH_BYTES = 65536;
    localparam int BLOCK_BYTES = 4096;
    localparam int BUFFER_MAX  = 4096;

    localparam int ADDR_W  = $clog2(FLASH_BYTES);
    localparam int BLK_W   = $clog2(BLOCK_BYTES);
    localparam int CNT_W   = $clog2(BUFFER_MAX + 1);
    localparam int CFG_IDX_W = 1;

    // Command bytes
    localparam logic [7:0] CMD_READ_ARRAY = 8'hff;
    localparam logic [7:0] CMD_READ_ID    = 8'h90;
    localparam logic [7:0] CMD_QUERY      = 8'h98;
    localparam logic [7:0] CMD_PROGRAM    = 8'h10;
    localparam logic [7:0] CMD_BUF_PROG   = 8'he8;
    localparam logic [7:0] CMD_ERASE      = 8'h20;
    localparam logic [7:0] CMD_CONFIRM    = 8'hd0;

    localparam logic [7:0]  ERASED_BYTE  = 8'hff;
    localparam logic [31:0] STATUS_READY = 32'h0000_0080;

    localparam logic [15:0] ID_VENDOR_OFS = 16'd0;
    localparam logic [15:0] ID_DEVICE_OFS = 16'd4;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VENDOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE = 1'b1;

    typedef enum logic [3:0] {
        M_ARRAY   = 4'd0,
        M_STATUS  = 4'd1,
        M_ID      = 4'd2,
        M_QUERY   = 4'd3,
        M_PROG    = 4'd4,
        M_COUNT   = 4'd5,
        M_LOAD    = 4'd6,
        M_CONFIRM = 4'd7,
        M_ERASE   = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORK,
        ST_ERASE
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [15:0] data;
    } acc_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  mode_now;
    } res_t;

    typedef struct packed {
        logic [31:0] vendor_code;
        logic [31:0] device_code;
    } id_codes_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Command decode; anything unknown keeps the current mode
    function automatic mode_t decode_cmd(input logic [7:0] cmd, input mode_t cur);
        mode_t m;
        unique case (cmd)
            CMD_READ_ARRAY: m = M_ARRAY;
            CMD_READ_ID:    m = M_ID;
            CMD_QUERY:      m = M_QUERY;
            CMD_PROGRAM:    m = M_PROG;
            CMD_BUF_PROG:   m = M_COUNT;
            CMD_ERASE:      m = M_ERASE;
            default:        m = cur;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nfc_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_store
// Flash array storage: one shared port, synchronous read with registered data.
// ----------------------------------------------------------------------------
module nfc_store (
    input  wire logic              clk,
    input  wire nfc_pkg::mem_req_t req,
    output logic [7:0]             rdata
);

    logic [7:0] mem [nfc_pkg::FLASH_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/nfc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_ctrl
// Command state machine: reads the array on accept, modifies and writes back when
// the output is free, and walks the array for the reset clear and block erase.
// ----------------------------------------------------------------------------
module nfc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               acc_valid,
    output logic                    acc_ready,
    input  wire nfc_pkg::acc_t      acc,
    input  wire nfc_pkg::id_codes_t ids,
    input  wire logic               res_busy,
    output logic                    res_load,
    output nfc_pkg::res_t           res_data,
    output nfc_pkg::mem_req_t       mem_req,
    input  wire logic [7:0]         mem_rdata
);

    nfc_pkg::state_t                       state_reg, state_next;
    nfc_pkg::mode_t                        mode_reg, mode_next, mode_w;
    logic [nfc_pkg::CNT_W-1:0]             bl_reg, bl_next, bl_w, bl_dec;
    logic [nfc_pkg::ADDR_W-1:0]            cnt_reg, cnt_next;
    logic [nfc_pkg::ADDR_W-nfc_pkg::BLK_W-1:0] blk_reg;
    nfc_pkg::acc_t                         item_reg;

    logic [7:0]                  wbyte;
    logic [nfc_pkg::ADDR_W-1:0]  off;
    logic [31:0]                 rd;
    logic                        prog;
    logic                        erase_hit;
    logic                        advance;

    assign wbyte   = item_reg.data[7:0];
    assign off     = item_reg.address[nfc_pkg::ADDR_W-1:0];
    assign advance = (state_reg == nfc_pkg::ST_WORK) && !res_busy;
    assign bl_dec  = (bl_reg != '0) ? bl_reg - 1'b1 : bl_reg;

    // Result and next mode for the held beat
    always_comb
    begin
        rd        = '0;
        mode_w    = mode_reg;
        bl_w      = bl_reg;
        prog      = 1'b0;
        erase_hit = 1'b0;
        if (item_reg.kind == nfc_pkg::KIND_READ)
        begin
            unique case (mode_reg)
                nfc_pkg::M_ARRAY: rd = {24'b0, mem_rdata};
                nfc_pkg::M_ID:
                begin
                    if (item_reg.address == nfc_pkg::ID_VENDOR_OFS)
                        rd = ids.vendor_code;
                    else if (item_reg.address == nfc_pkg::ID_DEVICE_OFS)
                        rd = ids.device_code;
                    else
                        rd = '0;
                end
                nfc_pkg::M_QUERY: rd = '0;
                default:          rd = nfc_pkg::STATUS_READY;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                nfc_pkg::M_PROG:
                begin
                    prog   = 1'b1;
                    mode_w = nfc_pkg::M_STATUS;
                end
                nfc_pkg::M_COUNT:
                begin
                    // count field holds length minus one; saturate at buffer size
                    if (32'(item_reg.data) >= nfc_pkg::BUFFER_MAX - 1)
                        bl_w = nfc_pkg::CNT_W'(nfc_pkg::BUFFER_MAX);
                    else
                        bl_w = nfc_pkg::CNT_W'(item_reg.data) + 1'b1;
                    mode_w = nfc_pkg::M_LOAD;
                end
                nfc_pkg::M_LOAD:
                begin
                    prog = 1'b1;
                    bl_w = bl_dec;
                    if (bl_dec == '0)
                        mode_w = nfc_pkg::M_CONFIRM;
                end
                nfc_pkg::M_CONFIRM:
                begin
                    if (wbyte == nfc_pkg::CMD_CONFIRM)
                        mode_w = nfc_pkg::M_STATUS;
                    else
                        mode_w = nfc_pkg::decode_cmd(wbyte, mode_reg);
                end
                nfc_pkg::M_ERASE:
                begin
                    if (wbyte == nfc_pkg::CMD_CONFIRM)
                    begin
                        erase_hit = 1'b1;
                        mode_w    = nfc_pkg::M_STATUS;
                    end
                    else
                    begin
                        mode_w = nfc_pkg::decode_cmd(wbyte, mode_reg);
                    end
                end
                default: mode_w = nfc_pkg::decode_cmd(wbyte, mode_reg);
            endcase
        end
    end

    assign res_data.read_data = rd;
    assign res_data.mode_now  = mode_w;

    assign mode_next = advance ? mode_w : mode_reg;
    assign bl_next   = advance ? bl_w : bl_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if ((state_reg == nfc_pkg::ST_CLEAR) || (state_reg == nfc_pkg::ST_ERASE))
            cnt_next = cnt_reg + 1'b1;
        else if (advance && erase_hit)
            cnt_next = '0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfc_pkg::ST_CLEAR:
            begin
                if (cnt_reg == nfc_pkg::ADDR_W'(nfc_pkg::FLASH_BYTES - 1))
                    state_next = nfc_pkg::ST_IDLE;
            end
            nfc_pkg::ST_IDLE:
            begin
                if (acc_valid)
                    state_next = nfc_pkg::ST_WORK;
            end
            nfc_pkg::ST_WORK:
            begin
                if (!res_busy)
                    state_next = erase_hit ? nfc_pkg::ST_ERASE : nfc_pkg::ST_IDLE;
            end
            nfc_pkg::ST_ERASE:
            begin
                if (&cnt_reg[nfc_pkg::BLK_W-1:0])
                    state_next = nfc_pkg::ST_IDLE;
            end
            default: state_next = nfc_pkg::ST_CLEAR;
        endcase
    end

    // Outputs and memory port
    always_comb
    begin
        acc_ready     = 1'b0;
        res_load      = advance;
        mem_req.rd_en = 1'b0;
        mem_req.wr_en = 1'b0;
        mem_req.addr  = off;
        mem_req.wdata = nfc_pkg::ERASED_BYTE;
        unique case (state_reg)
            nfc_pkg::ST_CLEAR:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = cnt_reg;
            end
            nfc_pkg::ST_IDLE:
            begin
                acc_ready     = 1'b1;
                mem_req.rd_en = acc_valid;
                mem_req.addr  = acc.address[nfc_pkg::ADDR_W-1:0];
            end
            nfc_pkg::ST_WORK:
            begin
                // AND the byte in: a NOR cell only clears bits
                mem_req.wr_en = prog && !res_busy;
                mem_req.wdata = mem_rdata & wbyte;
            end
            nfc_pkg::ST_ERASE:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = {blk_reg, cnt_reg[nfc_pkg::BLK_W-1:0]};
            end
            default:
            begin
                mem_req.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfc_pkg::ST_CLEAR;
            mode_reg  <= nfc_pkg::M_ARRAY;
            bl_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            bl_reg    <= bl_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_valid && acc_ready)
            item_reg <= acc;
        if (advance && erase_hit)
            blk_reg <= off[nfc_pkg::ADDR_W-1:nfc_pkg::BLK_W];
    end

endmodule
`default_nettype wire

@@ hw/rtl/nor_flash_command_model.sv @@
`default_nettype none
// A result is registered once the controller's work state finds the output free.
// A new access is taken only in idle, after the array read on accept and
//   the modify/write-back on the single memory port.
// A confirmed block erase fills all BLOCK_BYTES (4096) bytes of its block with 0xff.
// Reset: mode read array, ID codes zero; a clearing pass over FLASH_BYTES (65536)
//   bytes fills the array with 0xff before the first access is accepted.
// ----------------------------------------------------------------------------
// nor_flash_command_model
// Byte-wide NOR flash with a command state machine and a registered result.
// ----------------------------------------------------------------------------
module nor_flash_command_model (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          acc_valid,
    output logic                               acc_ready,
    input  wire nfc_pkg::acc_t                 acc,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output nfc_pkg::res_t                      res,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    nfc_pkg::id_codes_t ids_reg;
    logic               res_valid_reg, res_valid_next;
    nfc_pkg::res_t      res_reg;
    nfc_pkg::res_t      res_data;
    nfc_pkg::mem_req_t  mem_req;
    logic [7:0]         mem_rdata;
    logic               res_load;
    logic               res_busy;

    assign cfg_ready = 1'b1;
    assign res_busy  = res_valid_reg && !res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nfc_pkg::REG_VENDOR: ids_reg.vendor_code <= cfg_data;
                nfc_pkg::REG_DEVICE: ids_reg.device_code <= cfg_data;
                default:             ids_reg <= ids_reg;
            endcase
        end
    end

    // Hold the result until taken; the controller waits while it is held
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_data;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    nfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .ids       (ids_reg),
        .res_busy  (res_busy),
        .res_load  (res_load),
        .res_data  (res_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    nfc_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/nfc_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_chk
// Port-level checks for the NOR flash command model, bound to the top level.
// ----------------------------------------------------------------------------
module nfc_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          acc_valid,
    input wire logic                          acc_ready,
    input wire nfc_pkg::acc_t                 acc,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire nfc_pkg::res_t                 res,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [nfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [31:0]                   cfg_data
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat dropped or changed while stalled");

    // an accepted access occupies the array port for the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid && acc_ready |=> !acc_ready)
        else $error("access accepted while another is in flight");

    // with the output free at accept, the result is registered without a stall
    a_res_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid && acc_ready && !res_valid |=> ##1 res_valid)
        else $error("result missing after accepted access");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.mode_now <= 4'd8)
        else $error("result reports an undefined mode");

endmodule

bind nor_flash_command_model nfc_chk u_nfc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc       (acc),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
`default_nettype wire

@@ dv/nfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_checker
// Watches the access, result and register channels of the NOR flash command
// model, keeps its own copy of the array, the command mode and the ID codes,
// and compares every result beat against the predicted one in order.
// ----------------------------------------------------------------------------
module nfc_checker
    import nfc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 acc_valid,
    input  wire logic                 acc_ready,
    input  wire acc_t                 acc,
    input  wire logic                 res_valid,
    input  wire logic                 res_ready,
    input  wire res_t                 res,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output int                        mismatches,
    output int                        due
);

    logic [7:0]  flash_mem [FLASH_BYTES];
    mode_t       cur_mode;
    int          load_left;
    logic [31:0] vendor_id;
    logic [31:0] device_id;
    res_t        expected_q [$];

    function automatic mode_t cmd_mode(input logic [7:0] cmd, input mode_t keep);
        case (cmd)
            CMD_READ_ARRAY: return M_ARRAY;
            CMD_READ_ID:    return M_ID;
            CMD_QUERY:      return M_QUERY;
            CMD_PROGRAM:    return M_PROG;
            CMD_BUF_PROG:   return M_COUNT;
            CMD_ERASE:      return M_ERASE;
            default:        return keep;
        endcase
    endfunction

    // Apply one bus access to the shadow flash and return what the block reports
    function automatic res_t flash_access(input acc_t a);
        res_t       r;
        logic [7:0] b;
        int         ofs;
        int         base;
        b           = a.data[7:0];
        ofs         = int'(a.address) % FLASH_BYTES;
        r.read_data = 32'h0;
        if (a.kind == KIND_READ)
        begin
            case (cur_mode)
                M_ARRAY: r.read_data = {24'h0, flash_mem[ofs]};
                M_ID:    r.read_data = (a.address == ID_VENDOR_OFS) ? vendor_id :
                                       (a.address == ID_DEVICE_OFS) ? device_id : 32'h0;
                M_QUERY: r.read_data = 32'h0;
                default: r.read_data = STATUS_READY;
            endcase
        end
        else
        begin
            case (cur_mode)
                M_PROG:
                begin
                    flash_mem[ofs] &= b;
                    cur_mode = M_STATUS;
                end
                M_COUNT:
                begin
                    load_left = (int'(a.data) + 1 > BUFFER_MAX) ? BUFFER_MAX : int'(a.data) + 1;
                    cur_mode  = M_LOAD;
                end
                M_LOAD:
                begin
                    flash_mem[ofs] &= b;
                    if (load_left > 0)
                        load_left--;
                    if (load_left == 0)
                        cur_mode = M_CONFIRM;
                end
                M_CONFIRM:
                    cur_mode = (b == CMD_CONFIRM) ? M_STATUS : cmd_mode(b, cur_mode);
                M_ERASE:
                begin
                    if (b == CMD_CONFIRM)
                    begin
                        // clear the whole block that holds the address, never past the end
                        base = ofs - (ofs % BLOCK_BYTES);
                        for (int i = 0; i < BLOCK_BYTES && base + i < FLASH_BYTES; i++)
                            flash_mem[base + i] = ERASED_BYTE;
                        cur_mode = M_STATUS;
                    end
                    else
                        cur_mode = cmd_mode(b, cur_mode);
                end
                default:
                    cur_mode = cmd_mode(b, cur_mode);
            endcase
        end
        r.mode_now = cur_mode;
        return r;
    endfunction

    function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FLASH_BYTES; i++)
                flash_mem[i] = ERASED_BYTE;
            cur_mode   = M_ARRAY;
            load_left  = 0;
            vendor_id  = 32'h0;
            device_id  = 32'h0;
            expected_q.delete();
            mismatches = 0;
            due        = 0;
        end
        else
        begin
            // retire the result beat before queuing the access taken at this edge
            if (res_valid && res_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing pending: read_data %h mode_now %0d",
                                 $realtime, res.read_data, res.mode_now);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res.read_data !== want.read_data)
                        flag_mismatch("read_data", want.read_data, res.read_data);
                    if (res.mode_now !== want.mode_now)
                        flag_mismatch("mode_now", 32'(want.mode_now), 32'(res.mode_now));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VENDOR)
                    vendor_id = cfg_data;
                else
                    device_id = cfg_data;
            end
            if (acc_valid && acc_ready)
                expected_q.push_back(flash_access(acc));
            due = expected_q.size();
        end
    end

endmodule

@@ dv/tb_nor_flash_command_model.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nor_flash_command_model
// Drives bus reads and writes into the NOR flash command model: a short
// directed pass over every mode and command, then random command sequences
// over several ID code settings, random gaps on both channels in all but one.
// ----------------------------------------------------------------------------
module tb_nor_flash_command_model;
    import nfc_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 acc_valid = 1'b0;
    logic                 acc_ready;
    acc_t                 acc       = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    res_t                 res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_VENDOR;
    logic [31:0]          cfg_data  = 32'h0;

    int                   mismatch_count;
    int                   results_due;
    int                   issued       = 0;
    int                   erase_budget = 30;
    logic                 calm         = 1'b0;
    logic [15:0]          hot_base     = 16'h0;

    nor_flash_command_model u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc       (acc),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nfc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_valid  (acc_valid),
        .acc_ready  (acc_ready),
        .acc        (acc),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatch_count),
        .due        (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        res_ready <= calm || ($urandom_range(99) >= 22);

    // Offer one access beat and hold it until taken; returns at a falling edge
    task automatic put_access(input logic kind, input logic [15:0] addr,
                              input logic [15:0] dat);
        acc_t beat;
        beat.kind    = kind;
        beat.address = addr;
        beat.data    = dat;
        while (!calm && $urandom_range(99) < 22)
        begin
            acc_valid <= 1'b0;
            @(negedge clk);
        end
        acc_valid <= 1'b1;
        acc       <= beat;
        do
            @(posedge clk);
        while (!acc_ready);
        @(negedge clk);
        issued++;
    endtask

    task automatic bus_read(input logic [15:0] addr);
        put_access(KIND_READ, addr, 16'($urandom));
    endtask

    task automatic bus_write(input logic [15:0] addr, input logic [15:0] dat);
        put_access(KIND_WRITE, addr, dat);
    endtask

    // Drop valid and hold until every result beat has come back
    task automatic wait_results();
        acc_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
    endtask

    task automatic set_id_codes(input logic [31:0] vendor, input logic [31:0] device);
        cfg_valid <= 1'b1;
        cfg_index <= REG_VENDOR;
        cfg_data  <= vendor;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= REG_DEVICE;
        cfg_data  <= device;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly addresses inside a small window, so reads land on programmed bytes
    function automatic logic [15:0] pick_addr();
        if ($urandom_range(9) < 6)
            return {hot_base[15:6], 6'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] any_cmd();
        logic [7:0] codes [7];
        codes = '{CMD_READ_ARRAY, CMD_READ_ID, CMD_QUERY, CMD_PROGRAM,
                  CMD_BUF_PROG, CMD_ERASE, CMD_CONFIRM};
        if ($urandom_range(9) < 3)
            return 8'($urandom);
        return codes[$urandom_range(6)];
    endfunction

    task automatic random_sequence();
        int          pick;
        int          n;
        logic [15:0] a;
        logic [15:0] d;
        pick = $urandom_range(99);
        a    = pick_addr();
        if (pick < 28)
        begin
            bus_write(pick_addr(), CMD_PROGRAM);
            if ($urandom_range(3) == 0)
                bus_read(pick_addr());
            bus_write(a, 16'($urandom));
            bus_read(pick_addr());
            bus_write(pick_addr(), CMD_READ_ARRAY);
            bus_read(a);
        end
        else if (pick < 52)
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(7);
            bus_write(a, CMD_BUF_PROG);
            if ($urandom_range(3) == 0)
                bus_read(a);
            bus_write(a, 16'(n));
            for (int i = 0; i <= n; i++)
            begin
                if ($urandom_range(5) == 0)
                    bus_read(pick_addr());
                bus_write(a + 16'(i), 16'($urandom));
            end
            if ($urandom_range(3) == 0)
                bus_read(a);
            if ($urandom_range(9) == 0)
                bus_write(pick_addr(), any_cmd());
            else
                bus_write(a, CMD_CONFIRM);
            bus_write(pick_addr(), CMD_READ_ARRAY);
            bus_read(a);
            bus_read(a + 16'(n));
        end
        else if (pick < 58)
        begin
            bus_write(a, CMD_ERASE);
            if ($urandom_range(3) == 0)
                bus_read(pick_addr());
            // each real erase walks a whole block, so ration them
            if (erase_budget > 0 && $urandom_range(4) != 0)
            begin
                erase_budget--;
                bus_write(a, CMD_CONFIRM);
                bus_read(a);
            end
            else
                bus_write(pick_addr(), any_cmd());
            bus_write(pick_addr(), CMD_READ_ARRAY);
            bus_read(a);
        end
        else if (pick < 70)
        begin
            bus_write(pick_addr(), CMD_READ_ID);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(3))
                    0:       bus_read(ID_VENDOR_OFS);
                    1:       bus_read(ID_DEVICE_OFS);
                    default: bus_read(pick_addr());
                endcase
            end
            if ($urandom_range(3) == 0)
                bus_write(pick_addr(), any_cmd());
        end
        else if (pick < 80)
        begin
            bus_write(pick_addr(), CMD_QUERY);
            repeat ($urandom_range(1, 3))
                bus_read(pick_addr());
            if ($urandom_range(2) == 0)
                bus_write(pick_addr(), any_cmd());
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                d = 16'($urandom);
                if ($urandom_range(3) != 0)
                    d[15:8] = 8'h00;
                // keep noise from opening a full-size buffer
                if (d[7:0] == CMD_BUF_PROG)
                    d[0] = ~d[0];
                put_access(1'($urandom), 16'($urandom), d);
            end
        end
    endtask

    initial
    begin
        int phase_end;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // ID mode with the codes still at their reset value
        bus_read(16'h0000);
        bus_write(16'h0000, CMD_READ_ID);
        bus_read(ID_VENDOR_OFS);
        bus_read(ID_DEVICE_OFS);
        bus_read(16'h0005);
        wait_results();
        set_id_codes($urandom, $urandom);
        bus_read(ID_VENDOR_OFS);
        bus_read(ID_DEVICE_OFS);
        // query mode, then an unknown command and a stray confirm leave the mode alone
        bus_write(16'h1234, CMD_QUERY);
        bus_read(16'h1234);
        bus_write(16'h0000, 16'h0055);
        bus_write(16'h0000, CMD_CONFIRM);
        // single byte program at the top of the array
        bus_write(16'hffff, CMD_PROGRAM);
        bus_read(16'hffff);
        bus_write(16'hffff, 16'h00a5);
        bus_write(16'h0000, CMD_READ_ARRAY);
        bus_read(16'hffff);
        // one-byte buffer, then confirm
        bus_write(16'hfffe, CMD_BUF_PROG);
        bus_write(16'hfffe, 16'h0000);
        bus_write(16'hfffe, 16'h5a0f);
        bus_read(16'hfffe);
        bus_write(16'hfffe, CMD_CONFIRM);
        // two-byte buffer closed by a command instead of confirm
        bus_write(16'h0000, CMD_BUF_PROG);
        bus_write(16'h0000, 16'h0001);
        bus_write(16'h0000, 16'h0000);
        bus_write(16'h0001, 16'h00ff);
        bus_write(16'h0000, CMD_READ_ID);
        // erase setup dropped by another command, then a real erase of the last block
        bus_write(16'h0000, CMD_ERASE);
        bus_write(16'h0000, CMD_READ_ARRAY);
        bus_read(16'h0000);
        bus_write(16'hf000, CMD_ERASE);
        bus_write(16'hffff, CMD_CONFIRM);
        bus_write(16'h0000, CMD_READ_ARRAY);
        bus_read(16'hffff);

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_results();
            case (phase)
                0:       set_id_codes(32'h0000_0000, 32'h0000_0000);
                1:       set_id_codes(32'hffff_ffff, 32'hffff_ffff);
                3:       set_id_codes(32'h0000_0000, 32'hffff_ffff);
                4:       set_id_codes(32'hffff_ffff, $urandom);
                default: set_id_codes($urandom, $urandom);
            endcase
            hot_base = 16'($urandom);
            calm    <= (phase == 2);
            phase_end = issued + 290;
            while (issued < phase_end)
                random_sequence();
        end

        wait_results();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("[nor_flash_command_model] OK");
        else
            $display("[nor_flash_command_model] ERROR");
        $finish;
    end

    initial
    begin
        #12ms;
        $display("[nor_flash_command_model] ERROR");
        $finish;
    end

endmodule

@@ nor_flash_command_model.f @@
hw/rtl/nfc_pkg.sv
hw/rtl/nfc_store.sv
hw/rtl/nfc_ctrl.sv
hw/rtl/nor_flash_command_model.sv
hw/rtl/nfc_chk.sv
dv/nfc_checker.sv
dv/tb_nor_flash_command_model.sv
